### rtl/plcmd_pkg.sv
// Shared types, constants and helper functions for the press-length counter display.
package plcmd_pkg;

  // Field and port widths
  localparam int unsigned TickW  = 16;
  localparam int unsigned SegW   = 8;
  localparam int unsigned EnW    = 4;
  localparam int unsigned CountW = 14;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // Register reset values
  localparam logic [TickW-1:0] LongPressReset  = 16'd7813;
  localparam logic [TickW-1:0] ClearPressReset = 16'd31249;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgLongPress  = 1'b0,
    CfgClearPress = 1'b1
  } cfg_idx_e;

  // Press classification, one request at a time
  typedef struct packed {
    logic add_one;
    logic add_ten;
    logic clear;
  } press_evt_t;

  // Active-low 7-segment pattern of a decimal digit
  function automatic logic [SegW-1:0] seg_pattern(logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h83;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h98;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

  // Digit k of the power-up count 1801, ones first; higher digits are zero
  function automatic logic [3:0] reset_digit(int k);
    logic [3:0] d;
    case (k)
      0:       d = 4'd1;
      1:       d = 4'd0;
      2:       d = 4'd8;
      3:       d = 4'd1;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  // Binary value of the power-up count over n digits, low bits only
  function automatic logic [CountW-1:0] reset_count(int n);
    logic [31:0] v;
    v = '0;
    for (int k = n - 1; k >= 0; k--) begin
      v = 32'((v * 32'd10) + 32'(reset_digit(k)));
    end
    return v[CountW-1:0];
  endfunction

  // 10^n reduced to the binary count width
  function automatic logic [CountW-1:0] pow10_mod(int n);
    logic [31:0] v;
    v = 32'd1;
    for (int k = 0; k < n; k++) begin
      v = 32'((v * 32'd10) & ((32'd1 << CountW) - 32'd1));
    end
    return v[CountW-1:0];
  endfunction

endpackage

### rtl/plcmd_press.sv
// Press timer: holds the tick limits, times the press and classifies it on release.
module plcmd_press
  import plcmd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             button_i,
  input  logic             dtick_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_addr_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  output press_evt_t       evt_o
);

  logic [TickW-1:0] long_q, clear_lim_q;
  logic             last_q, last_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic             cleared_q, cleared_d;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q      <= LongPressReset;
      clear_lim_q <= ClearPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgLongPress:  long_q      <= cfg_wdata_i;
        CfgClearPress: clear_lim_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Press timing; the tick on the press edge itself is not counted
  always_comb begin
    last_d    = button_i;
    ticks_d   = ticks_q;
    cleared_d = cleared_q;
    evt_o     = '0;
    if (button_i) begin
      if (!last_q) begin
        ticks_d   = '0;
        cleared_d = 1'b0;
      end else if (dtick_i) begin
        if (ticks_q < clear_lim_q) begin
          ticks_d = ticks_q + TickW'(1);
        end
        if (ticks_d >= clear_lim_q) begin
          cleared_d = 1'b1;
        end
      end
    end else if (last_q) begin
      // release edge: clear wins over long, long over short
      if (cleared_q) begin
        evt_o.clear = 1'b1;
      end else if (ticks_q < long_q) begin
        evt_o.add_one = 1'b1;
      end else begin
        evt_o.add_ten = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      ticks_q   <= '0;
      cleared_q <= 1'b0;
    end else if (step_i) begin
      last_q    <= last_d;
      ticks_q   <= ticks_d;
      cleared_q <= cleared_d;
    end
  end

endmodule

### rtl/plcmd_counter.sv
// Decimal counter: BCD digits with a binary copy of the count kept alongside.
module plcmd_counter
  import plcmd_pkg::*;
#(
  parameter int unsigned DigitCount = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  press_evt_t                       evt_i,
  output logic [DigitCount-1:0][3:0]       digits_d_o,
  output logic [CountW-1:0]                count_o
);

  localparam logic [CountW-1:0] WrapMod  = pow10_mod(DigitCount);
  localparam logic [CountW-1:0] CountRst = reset_count(DigitCount);

  logic [DigitCount-1:0][3:0] digits_q, digits_d;
  logic [CountW-1:0]          count_q, count_d;
  logic                       carry, cin, wrap;
  logic [3:0]                 sum;
  logic [CountW-1:0]          inc;

  // Carry chain over the digits, ones first
  always_comb begin
    digits_d = digits_q;
    carry    = evt_i.add_one;
    cin      = 1'b0;
    sum      = '0;
    for (int k = 0; k < int'(DigitCount); k++) begin
      cin = carry | ((k == 1) & evt_i.add_ten);
      sum = digits_q[k] + 4'(cin);
      if (sum == 4'd10) begin
        digits_d[k] = '0;
        carry       = 1'b1;
      end else begin
        digits_d[k] = sum;
        carry       = 1'b0;
      end
    end
    wrap = carry;
    if (evt_i.clear) begin
      digits_d = '0;
    end
  end

  // Binary copy follows the same step, less 10^N on wrap
  always_comb begin
    if (evt_i.add_one) begin
      inc = CountW'(1);
    end else if (evt_i.add_ten && (DigitCount > 1)) begin
      inc = CountW'(10);
    end else begin
      inc = '0;
    end
    if (evt_i.clear) begin
      count_d = '0;
    end else begin
      count_d = count_q + inc - (wrap ? WrapMod : CountW'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(DigitCount); k++) begin
        digits_q[k] <= reset_digit(k);
      end
      count_q <= CountRst;
    end else if (step_i) begin
      digits_q <= digits_d;
      count_q  <= count_d;
    end
  end

  assign digits_d_o = digits_d;
  assign count_o    = count_q;

endmodule

### rtl/plcmd_scan.sv
// Display scanner: steps through the digits and latches the segment byte and digit enables.
module plcmd_scan
  import plcmd_pkg::*;
#(
  parameter int unsigned DigitCount = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       scan_tick_i,
  input  logic [DigitCount-1:0][3:0] digits_i,
  output logic [SegW-1:0]            seg_o,
  output logic [EnW-1:0]             en_o
);

  localparam int unsigned IdxW = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DigitCount - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic [EnW-1:0]  en_q, en_d;

  // Next digit on a scan tick; digit indexes past the enable width stay dark
  always_comb begin
    idx_d = idx_q;
    seg_d = seg_q;
    en_d  = en_q;
    if (scan_tick_i) begin
      seg_d = seg_pattern(digits_i[idx_q]);
      for (int j = 0; j < int'(EnW); j++) begin
        en_d[j] = (32'(idx_q) != 32'(j));
      end
      idx_d = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      seg_q <= '1;
      en_q  <= '1;
    end else if (step_i) begin
      idx_q <= idx_d;
      seg_q <= seg_d;
      en_q  <= en_d;
    end
  end

  assign seg_o = seg_q;
  assign en_o  = en_q;

endmodule

### rtl/press_length_counter_mux_display_core.sv
// Top level of the press-length counter with multiplexed 7-segment display.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------
//   s_axis    | in        | button level, duration tick, scan tick
//   m_axis    | out       | segment byte, digit enables, binary count
//   cfg       | in        | tick limits (long press, clear press)
//
// One request per clock unless m_axis stalls: a request sits in the input
// register, then one pass of press timing, carry chain and segment lookup
// writes the result register; throughput one request per cycle.
// The result register doubles as display state; it only advances when it
// is empty or being drained, so an m_axis stall backs up into s_axis.
// Reset (rst_ni low, async) loads count 1801, display dark, default limits.
module press_length_counter_mux_display_core
  import plcmd_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] button_pressed, [1] duration_tick, [2] scan_tick, [7:3] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] segment_pattern, [11:8] digit_enable_n, [25:12] count_value, [31:26] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [TickW-1:0]    cfg_wdata_i
);

  logic                       in_valid_q;
  logic [2:0]                 in_data_q;
  logic                       out_valid_q;
  logic                       step;
  press_evt_t                 evt;
  logic [DIGIT_COUNT-1:0][3:0] digits_d;
  logic [SegW-1:0]            seg;
  logic [EnW-1:0]             en;
  logic [CountW-1:0]          count;

  // Handshake: a held request moves on when the result slot is free
  assign step          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[2:0];
    end
  end

  plcmd_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .button_i    (in_data_q[0]),
    .dtick_i     (in_data_q[1]),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_o       (evt)
  );

  plcmd_counter #(
    .DigitCount (DIGIT_COUNT)
  ) u_counter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .evt_i      (evt),
    .digits_d_o (digits_d),
    .count_o    (count)
  );

  plcmd_scan #(
    .DigitCount (DIGIT_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .scan_tick_i (in_data_q[2]),
    .digits_i    (digits_d),
    .seg_o       (seg),
    .en_o        (en)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - SegW - EnW - CountW)'(0), count, en, seg};

endmodule

### tb/sv/press_length_counter_mux_display_core_test.sv
// Self-checking testbench for the press-length counter with multiplexed display.
`timescale 1ns / 1ps

module press_length_counter_mux_display_core_test;
  import plcmd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned ModeSpan   = 90;
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldLen    = 80;

  // active-low segments for digits 0..9
  localparam logic [SegW-1:0] SegLut [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h83, 8'hF8, 8'h80, 8'h98
  };

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [EnW-1:0]    enable_n;
    logic [SegW-1:0]   segments;
  } display_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_axis_tready;
  // [0] button_pressed, [1] duration_tick, [2] scan_tick, [7:3] zero
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_tready = 1'b0;
  // [7:0] segment_pattern, [11:8] digit_enable_n, [25:12] count_value, [31:26] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_addr = '0;
  logic [TickW-1:0]    cfg_wdata = '0;

  press_length_counter_mux_display_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // pending button samples and expected display words
  logic [InDataW-1:0] sample_q [$];
  display_t           display_exp_q [$];

  int unsigned tx_cnt = 0;
  int unsigned rx_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  display_t    got_word;
  display_t    want_word;

  // shadow copy of the counter state
  int unsigned      long_lim = LongPressReset;
  int unsigned      clear_lim = ClearPressReset;
  logic             held_last = 1'b0;
  int unsigned      held_ticks = 0;
  logic             held_cleared = 1'b0;
  logic [3:0]       digits [4] = '{4'd1, 4'd0, 4'd8, 4'd1};
  logic [1:0]       scan_pos = '0;
  logic [SegW-1:0]  shown_seg = 8'hFF;
  logic [EnW-1:0]   shown_en = 4'hF;

  function automatic int unsigned count_of_digits();
    return digits[3] * 1000 + digits[2] * 100 + digits[1] * 10 + digits[0];
  endfunction

  // advance the shadow state by one sample and return the display word it shows
  function automatic display_t press_display_next(logic [2:0] smp);
    display_t   r;
    int         pos;
    logic       carry;
    int unsigned cnt;
    if (smp[0]) begin
      if (!held_last) begin
        // press start: a tick in this sample is not counted
        held_ticks   = 0;
        held_cleared = 1'b0;
      end else if (smp[1]) begin
        if (held_ticks < clear_lim) held_ticks++;
        if (held_ticks >= clear_lim) held_cleared = 1'b1;
      end
    end else if (held_last) begin
      if (held_cleared) begin
        for (int k = 0; k < 4; k++) digits[k] = 4'd0;
      end else begin
        pos   = (held_ticks < long_lim) ? 0 : 1;
        carry = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (k >= pos && carry) begin
            if (digits[k] == 4'd9) begin
              digits[k] = 4'd0;
            end else begin
              digits[k] = digits[k] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    end
    held_last = smp[0];
    if (smp[2]) begin
      shown_seg = SegLut[digits[scan_pos]];
      shown_en  = ~(4'b0001 << scan_pos);
      scan_pos  = scan_pos + 2'd1;
    end
    cnt        = count_of_digits();
    r.segments = shown_seg;
    r.enable_n = shown_en;
    r.count    = cnt[CountW-1:0];
    return r;
  endfunction

  function automatic logic pause_now(int unsigned cnt, logic rx_side);
    idle_mode_e mode;
    mode = idle_mode_e'((cnt / ModeSpan) % 4);
    case (mode)
      IdleSender:   return !rx_side && ($urandom_range(99) < 66);
      IdleReceiver: return rx_side && ($urandom_range(99) < 66);
      IdleBoth:     return $urandom_range(99) < 35;
      default:      return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on request %0d: %s expected 0x%0h got 0x%0h",
               rx_cnt, what, want, got);
  endtask

  // driver: offers queued samples, predicts on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) begin
        display_exp_q.push_back(press_display_next(s_tdata[2:0]));
        tx_cnt <= tx_cnt + 1;
      end
      if (!s_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && !pause_now(tx_cnt, 1'b0)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps going
  always @(posedge clk_i) begin
    if (!hold_done && rx_cnt == HoldAt) begin
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted display word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        got_word = display_t'(m_axis_tdata[CountW+EnW+SegW-1:0]);
        if (display_exp_q.size() == 0) begin
          flag_mismatch("unexpected result, tdata", 0, m_axis_tdata);
        end else begin
          want_word = display_exp_q.pop_front();
          if (got_word.segments != want_word.segments)
            flag_mismatch("segment_pattern", want_word.segments, got_word.segments);
          if (got_word.enable_n != want_word.enable_n)
            flag_mismatch("digit_enable_n", want_word.enable_n, got_word.enable_n);
          if (got_word.count != want_word.count)
            flag_mismatch("count_value", want_word.count, got_word.count);
        end
        rx_cnt <= rx_cnt + 1;
      end
      m_tready <= (hold_left == 0 && !(!hold_done && rx_cnt == HoldAt))
                  && !pause_now(rx_cnt, 1'b1);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("press_length_counter_mux_display_core_test NOT OK");
      $finish;
    end
  end

  task automatic push_sample(logic btn, logic tick, logic scan);
    sample_q.push_back({5'b00000, scan, tick, btn});
  endtask

  // one well-formed press: edge, held samples with n_ticks counted ticks, release
  task automatic push_press(int n_ticks, int n_gaps);
    push_sample(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    while (n_ticks > 0 || n_gaps > 0) begin
      if (n_gaps == 0 || (n_ticks > 0 && $urandom_range(1) == 1)) begin
        push_sample(1'b1, 1'b1, 1'($urandom_range(1)));
        n_ticks--;
      end else begin
        push_sample(1'b1, 1'b0, 1'($urandom_range(1)));
        n_gaps--;
      end
    end
    push_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat ($urandom_range(2))
      push_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // wait until every request has come back, plus the pipeline depth;
  // checked mid-cycle so the driver's updates at the edge have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_tvalid || display_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TickW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgLongPress) long_lim = val;
    else clear_lim = val;
  endtask

  task automatic set_limits(int unsigned long_val, int unsigned clear_val);
    wait_drained();
    write_reg(CfgLongPress, TickW'(long_val));
    write_reg(CfgClearPress, TickW'(clear_val));
  endtask

  // hold length aimed at the thresholds, kept short
  function automatic int pick_ticks();
    int t;
    case ($urandom_range(7))
      0:       t = 0;
      1:       t = int'(long_lim) - 1;
      2:       t = int'(long_lim);
      3:       t = int'(long_lim) + 1;
      4:       t = int'(clear_lim) - 1;
      5:       t = int'(clear_lim);
      6:       t = int'(clear_lim) + 2;
      default: t = $urandom_range(20);
    endcase
    if (t < 0 || t > 24) t = $urandom_range(24);
    return t;
  endfunction

  task automatic run_random(int n);
    int stop_at;
    stop_at = sample_q.size() + n;
    while (sample_q.size() < stop_at) begin
      if ($urandom_range(99) < 15) begin
        // noise: arbitrary samples, may break a press apart
        repeat ($urandom_range(4, 1))
          push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        push_press(pick_ticks(), $urandom_range(3));
      end
    end
  endtask

  initial begin
    int n_tens;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-up count: scan all digits, stray release tick, short presses
    repeat (4) push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b1, 1'b0);
    push_sample(1'b1, 1'b1, 1'b1);
    push_sample(1'b1, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b1, 1'b1);
    push_sample(1'b0, 1'b1, 1'b1);

    // every press adds ten, never clears: drive the count up to the wrap
    set_limits(0, 65535);
    n_tens = (9990 - int'(count_of_digits()) + 9) / 10;
    if (n_tens < 0) n_tens = 0;
    repeat (n_tens) begin
      push_sample(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
      push_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    // ones presses carry through all digits and wrap past 9999
    set_limits(65535, 65535);
    repeat (12) push_press($urandom_range(2), $urandom_range(1));

    // small limits: short, exactly at the long threshold, clear with saturation
    set_limits(2, 4);
    push_press(1, 0);
    push_press(2, 0);
    push_press(6, 0);
    run_random(40);

    // zero limits: untimed press adds ten, first counted tick clears
    set_limits(0, 0);
    push_press(0, 0);
    push_press(1, 0);
    run_random(20);

    // long threshold above clear threshold: clear wins
    set_limits(10, 4);
    run_random(25);

    set_limits(1, 1);
    run_random(20);

    set_limits(65535, 2);
    run_random(20);

    set_limits(1, 65535);
    run_random(20);

    set_limits(5, 12);
    run_random(35);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && display_exp_q.size() == 0) begin
      $display("press_length_counter_mux_display_core_test OK");
    end else begin
      $display("press_length_counter_mux_display_core_test NOT OK");
    end
    $finish;
  end

endmodule
